/* hw/rtl/bbn_pkg.sv */
`default_nettype none
package bbn_pkg;

  localparam int RADIUS_W  = 3;
  localparam int DIM_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/bbn_div.sv */
`default_nettype none
module bbn_div import bbn_pkg::*; #(
  parameter int DIVIDEND_W = 16,
  parameter int DIVISOR_W  = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W:0]    rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    rem_s;
  logic                  fits;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_s = {rem[DIVISOR_W-1:0], quotient[DIVIDEND_W-1]};
    fits  = rem_s >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= fits ? rem_s - {1'b0, dvs} : rem_s;
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/box_blur_edge_normalized.sv */
`default_nettype none
// Border-normalised box blur. One pixel beat is taken at a time; a beat that
// releases an output sets up the window, reads its N in-frame pixels (up to
// (2r+1)^2, one per cycle from the line store), divides their sum in the
// serial divider (16-bit sum at the default MAX_RADIUS), and then holds its
// result while the previous one still waits at the output. Outputs lag by
// radius rows plus radius pixels; flush beats drain the rest after the frame.
module box_blur_edge_normalized import bbn_pkg::*; #(
  parameter int MAX_RADIUS = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  localparam int RING   = 2 * MAX_RADIUS + 2;
  localparam int RING_W = $clog2(RING);
  localparam int DEPTH  = RING * MAX_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int WIN_N  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int N_W    = $clog2(WIN_N + 1);
  localparam int SUM_W  = $clog2(WIN_N * 255 + 1);

  logic [RADIUS_W-1:0] radius;
  logic [DIM_W-1:0]    frame_width;
  logic [DIM_W-1:0]    frame_height;

  logic [WW-1:0]    w;
  logic [HW-1:0]    h;
  logic [RAD_W-1:0] r, rh, rv;
  logic [CNT_W-1:0] total, lag;

  state_t state, state_next;

  logic [CW-1:0]     in_col;
  logic [RING_W-1:0] in_ring;
  logic [CNT_W-1:0]  recv;
  logic [CW-1:0]     out_col;
  logic [RW-1:0]     out_row;
  logic [RING_W-1:0] out_ring;
  logic [CNT_W-1:0]  sent;

  logic [CW-1:0]     x0, x1, x_cur;
  logic [RW-1:0]     y1, y_cur;
  logic [RING_W-1:0] ring_cur;

  logic [CW-1:0]     sx0, sx1;
  logic [RW-1:0]     sy0, sy1;
  logic [RING_W-1:0] sring;
  logic [CW:0]       xe;
  logic [RW:0]       ye;
  logic [RING_W:0]   dy;

  logic [PIX_W-1:0] line_store [DEPTH];
  logic [PIX_W-1:0] mem_q;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic             rd_pend;

  logic [SUM_W-1:0] sum, sum_acc;
  logic [N_W-1:0]   n, n_acc;

  logic pix_ok, emit_go, in_acc, pix_wr;
  logic read_en, div_start, out_load, cfg_wr, cfg_known, last_px, row_end;
  logic div_done;
  logic [SUM_W-1:0] div_quo;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    if (frame_width == '0)                 w = WW'(1);
    else if (frame_width > DIM_W'(MAX_WIDTH > 2047 ? 2047 : MAX_WIDTH) ||
             int'(frame_width) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else                                   w = WW'(frame_width);
    if (frame_height == '0)                h = HW'(1);
    else if (int'(frame_height) > MAX_HEIGHT) h = HW'(MAX_HEIGHT);
    else                                   h = HW'(frame_height);
    r  = (int'(radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius);
    rh = (WW'(r) > w - WW'(1)) ? RAD_W'(w - WW'(1)) : r;
    rv = (HW'(r) > h - HW'(1)) ? RAD_W'(h - HW'(1)) : r;
    total = CNT_W'(w) * CNT_W'(h);
    lag   = CNT_W'(rv) * CNT_W'(w) + CNT_W'(rh);
  end

  always_comb begin
    pix_ok  = (in_data.operation == OP_PIXEL) && (recv < total);
    emit_go = pix_ok ? ((recv + CNT_W'(1) - sent) > lag)
                     : ((recv >= total) && (sent < total));
    last_px = (HW'(out_row) == h - HW'(1)) && (WW'(out_col) == w - WW'(1));
    row_end = (WW'(out_col) == w - WW'(1));
  end

  // window bounds of the current output
  always_comb begin
    sy0   = (out_row >= RW'(rv)) ? out_row - RW'(rv) : '0;
    ye    = (RW+1)'(out_row) + (RW+1)'(rv);
    sy1   = (ye > (RW+1)'(h - HW'(1))) ? RW'(h - HW'(1)) : RW'(ye);
    sx0   = (out_col >= CW'(rh)) ? out_col - CW'(rh) : '0;
    xe    = (CW+1)'(out_col) + (CW+1)'(rh);
    sx1   = (xe > (CW+1)'(w - WW'(1))) ? CW'(w - WW'(1)) : CW'(xe);
    dy    = (RING_W+1)'(out_row - sy0);
    sring = ((RING_W+1)'(out_ring) >= dy) ? RING_W'((RING_W+1)'(out_ring) - dy)
          : RING_W'((RING_W+1)'(out_ring) + (RING_W+1)'(RING) - dy);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid && emit_go) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_READ;
      ST_READ:  if (x_cur == x1 && y_cur == y1) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_OUT;
      ST_OUT:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    read_en   = (state == ST_READ);
    div_start = (state == ST_DRAIN);
    out_load  = (state == ST_OUT) && (!out_valid || out_ready);
    in_acc    = in_valid && in_ready;
    pix_wr    = in_acc && pix_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cfg_known = 1'b1;
    unique case (cfg_index)
      CFG_RADIUS, CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT: cfg_known = 1'b1;
      default: cfg_known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= '0;
      frame_width  <= DIM_W'(1024);
      frame_height <= DIM_W'(1024);
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_RADIUS:       radius       <= cfg_data[RADIUS_W-1:0];
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cfg_wr && cfg_known) || (out_load && last_px)) begin
      in_col   <= '0;
      in_ring  <= '0;
      recv     <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_ring <= '0;
      sent     <= '0;
    end else begin
      if (pix_wr) begin
        recv <= recv + CNT_W'(1);
        if (WW'(in_col) == w - WW'(1)) begin
          in_col  <= '0;
          in_ring <= (in_ring == RING_W'(RING - 1)) ? '0 : in_ring + RING_W'(1);
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if (out_load) begin
        sent <= sent + CNT_W'(1);
        if (row_end) begin
          out_col  <= '0;
          out_row  <= out_row + RW'(1);
          out_ring <= (out_ring == RING_W'(RING - 1)) ? '0 : out_ring + RING_W'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SETUP) begin
      x0       <= sx0;
      x1       <= sx1;
      x_cur    <= sx0;
      y_cur    <= sy0;
      y1       <= sy1;
      ring_cur <= sring;
    end else if (read_en) begin
      if (x_cur == x1) begin
        x_cur    <= x0;
        y_cur    <= y_cur + RW'(1);
        ring_cur <= (ring_cur == RING_W'(RING - 1)) ? '0 : ring_cur + RING_W'(1);
      end else begin
        x_cur <= x_cur + CW'(1);
      end
    end
  end

  assign wr_addr = AW'(in_ring) * AW'(MAX_WIDTH) + AW'(in_col);
  assign rd_addr = AW'(ring_cur) * AW'(MAX_WIDTH) + AW'(x_cur);

  always_ff @(posedge clk) begin
    if (pix_wr) line_store[wr_addr] <= in_data.pixel_in;
    mem_q <= line_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) rd_pend <= 1'b0;
    else     rd_pend <= read_en;
  end

  always_comb begin
    sum_acc = rd_pend ? sum + SUM_W'(mem_q) : sum;
    n_acc   = rd_pend ? n + N_W'(1) : n;
  end

  always_ff @(posedge clk) begin
    if (rst || state == ST_SETUP) begin
      sum <= '0;
      n   <= '0;
    end else begin
      sum <= sum_acc;
      n   <= n_acc;
    end
  end

  bbn_div #(
    .DIVIDEND_W(SUM_W),
    .DIVISOR_W (N_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum_acc),
    .divisor (n_acc),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.pixel_out  <= div_quo[PIX_W-1:0];
      out_data.frame_last <= last_px;
    end
  end

  a_sent_le_recv: assert property (@(posedge clk) disable iff (rst) sent <= recv)
    else $error("output count ran ahead of input count");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");
  a_accum_phase: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == ST_READ || state == ST_DRAIN))
    else $error("read data arrived outside the window sweep");
  a_window_size: assert property (@(posedge clk) disable iff (rst)
    n <= N_W'(WIN_N))
    else $error("window pixel count exceeded the largest window");

endmodule
`default_nettype wire

/* dv/box_blur_edge_normalized_test.sv */
`default_nettype none
module box_blur_edge_normalized_test;
  import bbn_pkg::*;

  localparam int MAX_R      = 7;
  localparam int MAX_W      = 1024;
  localparam int MAX_H      = 1024;
  localparam int RING       = 2 * MAX_R + 2;
  localparam int SETTLE     = 400;
  localparam int LIMIT      = 20_000_000;
  localparam int HOLD_LEN   = 600;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  box_blur_edge_normalized uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // blur state mirror
  bit [7:0]         rows_mem [RING*MAX_W];
  int unsigned      blur_r = 0, blur_w = 1024, blur_h = 1024;
  int unsigned      in_col = 0, in_ln = 0, out_col = 0, out_ln = 0;
  out_item_t        pending_pixels [$];
  bit               failed = 1'b0;
  bit               gaps_on = 1'b1;
  bit               hold_req = 1'b0;
  int unsigned      rand_beats = 0;
  longint unsigned  cycles = 0;

  task automatic emit_mean(int unsigned w, int unsigned h, int unsigned rh, int unsigned rv);
    int unsigned y0, y1, x0, x1, sum, n;
    out_item_t   res;
    y0 = (out_ln >= rv) ? out_ln - rv : 0;
    y1 = (out_ln + rv < h - 1) ? out_ln + rv : h - 1;
    x0 = (out_col >= rh) ? out_col - rh : 0;
    x1 = (out_col + rh < w - 1) ? out_col + rh : w - 1;
    sum = 0;
    n = 0;
    for (int unsigned y = y0; y <= y1; y++)
      for (int unsigned x = x0; x <= x1; x++) begin
        sum += rows_mem[(y % RING) * MAX_W + x];
        n++;
      end
    res.pixel_out  = 8'(sum / n);
    res.frame_last = (out_ln == h - 1) && (out_col == w - 1);
    pending_pixels.push_back(res);
    if (res.frame_last) begin
      in_col = 0; in_ln = 0; out_col = 0; out_ln = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_ln++;
      end
    end
  endtask

  task automatic blur_beat(in_item_t it);
    int unsigned w, h, r, rh, rv, lag, total, recv, sent;
    w = (blur_w < 1) ? 1 : (blur_w > MAX_W ? MAX_W : blur_w);
    h = (blur_h < 1) ? 1 : (blur_h > MAX_H ? MAX_H : blur_h);
    r = (blur_r > MAX_R) ? MAX_R : blur_r;
    rh = (r < w - 1) ? r : w - 1;
    rv = (r < h - 1) ? r : h - 1;
    lag = rv * w + rh;
    total = w * h;
    recv = in_ln * w + in_col;
    sent = out_ln * w + out_col;
    if (it.operation == OP_PIXEL && recv < total) begin
      rows_mem[(in_ln % RING) * MAX_W + in_col] = it.pixel_in;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_ln++;
      end
      recv++;
      if (recv - sent > lag) emit_mean(w, h, rh, rv);
    end else if (recv >= total && sent < total) begin
      emit_mean(w, h, rh, rv);
    end
  endtask

  task automatic send_beat(logic op, logic [7:0] px);
    int gap;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{operation: op, pixel_in: px};
    do @(posedge clk); while (!in_ready);
    blur_beat('{operation: op, pixel_in: px});
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_RADIUS:       blur_r = val[RADIUS_W-1:0];
      CFG_FRAME_WIDTH:  blur_w = val;
      CFG_FRAME_HEIGHT: blur_h = val;
      default:          return;
    endcase
    in_col = 0; in_ln = 0; out_col = 0; out_ln = 0;
  endtask

  task automatic set_frame(int r, int w, int h);
    write_reg(CFG_RADIUS, DIM_W'(r));
    write_reg(CFG_FRAME_WIDTH, DIM_W'(w));
    write_reg(CFG_FRAME_HEIGHT, DIM_W'(h));
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // npix pixels (with random flushes if noisy), then ndrain drains; drains may be pixels too
  task automatic push_frame(int npix, int ndrain, bit noisy);
    for (int i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(0, 9) == 0) send_beat(OP_FLUSH, 8'($urandom));
      send_beat(OP_PIXEL, pick_pixel());
    end
    for (int i = 0; i < ndrain; i++)
      send_beat($urandom_range(0, 3) != 0 ? OP_FLUSH : OP_PIXEL, 8'($urandom));
  endtask

  task automatic test_passthrough();
    set_frame(0, 4, 2);
    send_beat(OP_PIXEL, 8'h00);
    send_beat(OP_PIXEL, 8'hff);
    send_beat(OP_PIXEL, 8'h80);
    send_beat(OP_PIXEL, 8'h7f);
    push_frame(4, 2, 1'b0);
    drain_wait();
  endtask

  task automatic test_flush_cases();
    set_frame(1, 3, 3);
    send_beat(OP_FLUSH, 8'hff);
    send_beat(OP_PIXEL, 8'hff);
    send_beat(OP_FLUSH, 8'h00);
    push_frame(8, 6, 1'b0);
    send_beat(OP_FLUSH, 8'h55);
    drain_wait();
  endtask

  task automatic test_max_radius();
    set_frame(7, 3, 2);
    push_frame(6, 6, 1'b0);
    drain_wait();
    set_frame(7, 10, 10);
    push_frame(100, 80, 1'b1);
    drain_wait();
  endtask

  task automatic test_dim_extremes();
    set_frame(2, 0, 0);
    push_frame(1, 2, 1'b0);
    drain_wait();
    set_frame(3, 2047, 1);
    push_frame(40, 0, 1'b0);
    drain_wait();
    set_frame(1, 1, 2047);
    push_frame(40, 0, 1'b0);
    drain_wait();
  endtask

  task automatic test_unused_index();
    set_frame(1, 5, 3);
    push_frame(4, 0, 1'b0);
    drain_wait();
    write_reg(CFG_UNUSED, '1);
    push_frame(11, 8, 1'b0);
    drain_wait();
  endtask

  task automatic test_abandon();
    set_frame(2, 6, 5);
    push_frame(17, 0, 1'b0);
    drain_wait();
    write_reg(CFG_RADIUS, 11'd1);
    push_frame(30, 9, 1'b0);
    drain_wait();
  endtask

  task automatic test_backpressure();
    set_frame(1, 8, 6);
    hold_req = 1'b1;
    gaps_on = 1'b0;
    push_frame(48, 10, 1'b0);
    gaps_on = 1'b1;
    drain_wait();
  endtask

  task automatic test_random();
    int r, w, h, npix, ndrain, lagn;
    while (rand_beats < 150) begin
      r = $urandom_range(0, 7);
      w = $urandom_range(1, 20);
      h = $urandom_range(1, 8);
      gaps_on = $urandom_range(0, 3) != 0;
      set_frame(r, w, h);
      lagn = w * h;
      if ($urandom_range(0, 7) == 0) begin
        npix = $urandom_range(1, lagn);
        ndrain = 0;
      end else begin
        npix = lagn;
        ndrain = lagn + 2;
      end
      push_frame(npix, ndrain, 1'b1);
      rand_beats += npix + ndrain;
      drain_wait();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_passthrough();
    test_flush_cases();
    test_max_radius();
    test_unused_index();
    test_abandon();
    test_backpressure();
    test_dim_extremes();
    test_random();
    if (!failed) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = gaps_on ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    out_item_t exp_px;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected beat: pixel_out %0d frame_last %0d",
               out_data.pixel_out, out_data.frame_last);
        failed = 1'b1;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_data.pixel_out !== exp_px.pixel_out) begin
          $error("pixel_out expected %0d actual %0d", exp_px.pixel_out, out_data.pixel_out);
          failed = 1'b1;
        end
        if (out_data.frame_last !== exp_px.frame_last) begin
          $error("frame_last expected %0d actual %0d", exp_px.frame_last,
                 out_data.frame_last);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
`default_nettype wire
